// ===== sv/flhm_pkg.sv =====
// shared types and constants for the frame link health monitor
package flhm_pkg;

  localparam int unsigned CntW      = 32;
  localparam int unsigned OutCntW   = 32;
  localparam int unsigned MsW       = 16;
  localparam int unsigned RateW     = 20;
  localparam int unsigned MvW       = 12;
  localparam int unsigned DivW      = 32;
  localparam int unsigned DivCntW   = $clog2(DivW);
  localparam int unsigned MulAW     = 20;
  localparam int unsigned MulBW     = 12;

  localparam logic [MsW-1:0]   MsMax          = '1;
  localparam logic [RateW-1:0] FramesMax      = '1;
  localparam logic [RateW-1:0] RateMax        = '1;
  localparam logic [MulBW-1:0] MvScale        = 12'd3300;
  localparam logic [MulBW-1:0] RateScale      = 12'd1000;
  localparam logic [DivW-1:0]  MvRound        = 32'd2047;
  localparam logic [MsW-1:0]   MvFullScale    = 16'd4095;
  localparam logic [MsW-1:0]   TimeoutReset   = 16'd500;
  localparam logic [MsW-1:0]   RateWinReset   = 16'd1000;

  typedef enum logic {
    REQ_FRAME = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    FR_VALID  = 2'd0,
    FR_CRC    = 2'd1,
    FR_FORMAT = 2'd2,
    FR_NONE   = 2'd3
  } frame_result_e;

  typedef enum logic [1:0] {
    LINK_WAIT    = 2'd0,
    LINK_OK      = 2'd1,
    LINK_TIMEOUT = 2'd2
  } link_state_e;

  typedef enum logic {
    CFG_TIMEOUT  = 1'b0,
    CFG_RATE_WIN = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WB
  } seq_state_e;

  function automatic logic [MsW-1:0] sat_inc_ms(input logic [MsW-1:0] v);
    sat_inc_ms = (v == MsMax) ? MsMax : v + 1'b1;
  endfunction

endpackage

// ===== sv/frame_link_health_monitor.sv =====
// frame link health monitor: sequence, timeout, error and frame rate tracking
// a tick that closes the rate window passes through multiply, a 32-step shared restoring
//   divider and write-back before its result is valid; any other beat skips the divider
// a new beat is taken only in idle, after write-back of the last one; the next beat is taken
//   while the result register still waits, then the input stalls until it drains
// reset restores registers to 500 / 1000 and clears all counters, timers and link flags, not the result payload
module frame_link_health_monitor
  import flhm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [MsW-1:0]       cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [1:0]           frame_result_i,
  input  logic [7:0]           seq_i,
  input  logic [11:0]          adc_raw_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 seq_gap_o,
  output logic                 recovered_o,
  output logic                 timeout_raised_o,
  output logic                 summary_ready_o,
  output logic [1:0]           link_state_o,
  output logic [7:0]           last_seq_o,
  output logic [MvW-1:0]       latest_mv_o,
  output logic [OutCntW-1:0]   valid_total_o,
  output logic [OutCntW-1:0]   gap_total_o,
  output logic [OutCntW-1:0]   crc_total_o,
  output logic [OutCntW-1:0]   format_total_o,
  output logic [RateW-1:0]     window_fps_o
);

  seq_state_e state_q, state_d;

  logic [MsW-1:0]     timeout_q, rate_win_q;

  // captured beat
  logic               req_q;
  logic [1:0]         fr_q;
  logic [7:0]         seq_q;
  logic [11:0]        adc_q;

  // monitor state
  logic [7:0]         prev_seq_q, prev_seq_d;
  logic               seen_q, seen_d;
  logic [MvW-1:0]     mv_q, mv_d;
  logic               tmo_q, tmo_d;
  logic [MsW-1:0]     silence_q, silence_d;
  logic [MsW-1:0]     win_el_q, win_el_d;
  logic [RateW-1:0]   win_frames_q, win_frames_d;
  logic [CntW-1:0]    cnt_valid_q, cnt_valid_d;
  logic [CntW-1:0]    cnt_gap_q, cnt_gap_d;
  logic [CntW-1:0]    cnt_crc_q, cnt_crc_d;
  logic [CntW-1:0]    cnt_fmt_q, cnt_fmt_d;

  // shared multiply / divide unit
  logic [DivW-1:0]    num_q;
  logic [MsW-1:0]     dvsr_q;
  logic [MsW-1:0]     rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [DivW-1:0]    mul_p;
  logic [DivW-1:0]    addend;
  logic [MsW:0]       trial;
  logic               trial_ge;

  // divide by full scale: shift by 12 plus one correction step
  logic [MvW-1:0]     mv_quo;
  logic [MvW:0]       mv_rem;

  // result register
  logic               out_valid_q;
  logic               gap_o_q, rec_o_q, raised_o_q, ready_o_q;
  logic [1:0]         link_o_q;
  logic [RateW-1:0]   rate_o_q;

  logic               is_frame, win_close, need_div, wb_go;
  logic               gap_d, rec_d, raised_d;
  logic [MsW-1:0]     silence_inc, win_el_inc;
  logic [RateW-1:0]   rate_d;
  logic [1:0]         link_d;

  assign is_frame       = (req_type_e'(req_q) == REQ_FRAME);
  assign silence_inc    = sat_inc_ms(silence_q);
  assign win_el_inc     = sat_inc_ms(win_el_q);
  assign win_close      = !is_frame && (win_el_inc >= rate_win_q);
  assign need_div       = win_close;
  assign wb_go          = (state_q == ST_WB) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (is_frame) begin
      mul_a    = MulAW'(adc_q);
      mul_b    = MvScale;
      addend   = MvRound;
    end else begin
      mul_a    = win_frames_q;
      mul_b    = RateScale;
      addend   = DivW'(win_el_inc >> 1);
    end
    mul_p = DivW'(mul_a * mul_b);
  end

  assign trial    = {rem_q, num_q[DivW-1]};
  assign trial_ge = (trial >= {1'b0, dvsr_q});

  assign mv_quo = num_q[2*MvW-1:MvW];
  assign mv_rem = {1'b0, num_q[MvW-1:0]} + {1'b0, mv_quo};

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = need_div ? ST_DIV : ST_WB;
      end
      ST_DIV: begin
        if (div_cnt_q == DivCntW'(DivW - 1)) state_d = ST_WB;
      end
      ST_WB: begin
        if (wb_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    prev_seq_d   = prev_seq_q;
    seen_d       = seen_q;
    mv_d         = mv_q;
    tmo_d        = tmo_q;
    silence_d    = silence_q;
    win_el_d     = win_el_q;
    win_frames_d = win_frames_q;
    cnt_valid_d  = cnt_valid_q;
    cnt_gap_d    = cnt_gap_q;
    cnt_crc_d    = cnt_crc_q;
    cnt_fmt_d    = cnt_fmt_q;
    gap_d        = 1'b0;
    rec_d        = 1'b0;
    raised_d     = 1'b0;
    rate_d       = '0;
    if (is_frame) begin
      unique case (frame_result_e'(fr_q))
        FR_VALID: begin
          gap_d       = seen_q && (seq_q != prev_seq_q + 8'd1);
          rec_d       = tmo_q;
          if (gap_d) cnt_gap_d = cnt_gap_q + 1'b1;
          prev_seq_d  = seq_q;
          seen_d      = 1'b1;
          mv_d        = (mv_rem >= (MvW+1)'(MvFullScale)) ? mv_quo + 1'b1 : mv_quo;
          silence_d   = '0;
          tmo_d       = 1'b0;
          cnt_valid_d = cnt_valid_q + 1'b1;
          if (win_frames_q != FramesMax) win_frames_d = win_frames_q + 1'b1;
        end
        FR_CRC:    cnt_crc_d = cnt_crc_q + 1'b1;
        FR_FORMAT: cnt_fmt_d = cnt_fmt_q + 1'b1;
        FR_NONE:   ;
        default:   ;
      endcase
    end else begin
      silence_d = silence_inc;
      if (seen_q && !tmo_q && (silence_inc >= timeout_q)) begin
        tmo_d    = 1'b1;
        raised_d = 1'b1;
      end
      win_el_d = win_el_inc;
      if (win_close) begin
        rate_d       = (|num_q[DivW-1:RateW]) ? RateMax : num_q[RateW-1:0];
        win_el_d     = '0;
        win_frames_d = '0;
      end
    end
    if (!seen_d)    link_d = LINK_WAIT;
    else if (tmo_d) link_d = LINK_TIMEOUT;
    else            link_d = LINK_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      timeout_q    <= TimeoutReset;
      rate_win_q   <= RateWinReset;
      prev_seq_q   <= '0;
      seen_q       <= 1'b0;
      mv_q         <= '0;
      tmo_q        <= 1'b0;
      silence_q    <= '0;
      win_el_q     <= '0;
      win_frames_q <= '0;
      cnt_valid_q  <= '0;
      cnt_gap_q    <= '0;
      cnt_crc_q    <= '0;
      cnt_fmt_q    <= '0;
      out_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
          CFG_RATE_WIN: rate_win_q <= cfg_wdata_i;
          default:      ;
        endcase
      end
      if (state_q == ST_MUL) div_cnt_q <= '0;
      else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + 1'b1;
      if (wb_go) begin
        prev_seq_q   <= prev_seq_d;
        seen_q       <= seen_d;
        mv_q         <= mv_d;
        tmo_q        <= tmo_d;
        silence_q    <= silence_d;
        win_el_q     <= win_el_d;
        win_frames_q <= win_frames_d;
        cnt_valid_q  <= cnt_valid_d;
        cnt_gap_q    <= cnt_gap_d;
        cnt_crc_q    <= cnt_crc_d;
        cnt_fmt_q    <= cnt_fmt_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // beat capture, shared datapath and result payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= req_type_i;
      fr_q  <= frame_result_i;
      seq_q <= seq_i;
      adc_q <= adc_raw_i;
    end
    if (state_q == ST_MUL) begin
      num_q  <= mul_p + addend;
      dvsr_q <= win_el_inc;
      rem_q  <= '0;
    end else if (state_q == ST_DIV) begin
      rem_q <= trial_ge ? MsW'(trial - {1'b0, dvsr_q}) : trial[MsW-1:0];
      num_q <= {num_q[DivW-2:0], trial_ge};
    end
    if (wb_go) begin
      gap_o_q    <= gap_d;
      rec_o_q    <= rec_d;
      raised_o_q <= raised_d;
      ready_o_q  <= win_close;
      link_o_q   <= link_d;
      rate_o_q   <= rate_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign seq_gap_o        = gap_o_q;
  assign recovered_o      = rec_o_q;
  assign timeout_raised_o = raised_o_q;
  assign summary_ready_o  = ready_o_q;
  assign link_state_o     = link_o_q;
  assign window_fps_o     = rate_o_q;
  assign last_seq_o       = prev_seq_q;
  assign latest_mv_o      = mv_q;
  assign valid_total_o    = cnt_valid_q[OutCntW-1:0];
  assign gap_total_o      = cnt_gap_q[OutCntW-1:0];
  assign crc_total_o      = cnt_crc_q[OutCntW-1:0];
  assign format_total_o   = cnt_fmt_q[OutCntW-1:0];

  a_rate_only_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !summary_ready_o |-> window_fps_o == '0)
    else $error("frame rate set without a closed window");

  a_gap_needs_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seq_gap_o |-> link_state_o == LINK_OK)
    else $error("sequence gap reported without an ok link");

  a_raise_times_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timeout_raised_o |-> link_state_o == LINK_TIMEOUT)
    else $error("timeout raised but link not timed out");

  a_div_full_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WB && $past(state_q) == ST_DIV |-> $past(div_cnt_q) == DivCntW'(DivW - 1))
    else $error("divider left before all quotient bits");

endmodule
